### hw/rtl/cbdm_pkg.sv
// ----------------------------------------------------------------------------
// cbdm_pkg
// Shared constants, types and helper functions of the city-block band mask.
// ----------------------------------------------------------------------------
`default_nettype none

package cbdm_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int DIST_BITS = 8;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

  // Configuration register widths and port layout.
  localparam int GRID_W    = 7;
  localparam int GAP_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = (DIST_BITS > GAP_W) ? DIST_BITS : GAP_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP  = 2'd2;

  localparam logic [GRID_W-1:0] ROWS_RESET = GRID_W'(64);
  localparam logic [GRID_W-1:0] COLS_RESET = GRID_W'(64);
  localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(1);

  localparam logic CMD_MARK   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
  localparam logic [ROW_W-1:0]     ROW_LAST = ROW_W'(MAX_ROWS - 1);
  localparam logic [COL_W-1:0]     COL_LAST = COL_W'(MAX_COLS - 1);

  typedef logic [DIST_BITS-1:0] dist_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FWD   = 6'b000100,
    ST_BWD   = 6'b001000,
    ST_SWEEP = 6'b010000,
    ST_DRAIN = 6'b100000
  } state_t;

  // One pixel access in flight between the address issue and the update.
  typedef struct packed {
    logic             valid;
    logic             sweep;     // read out and overwrite with unreached
    logic             emit;      // sweep that reports band masks
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             use_a;     // vertical neighbor exists
    logic             use_b;     // horizontal neighbor exists
    logic             col_act;
    logic             row_act;
    logic             last_row;
  } stage_t;

  function automatic logic [ROW_CNT_W-1:0] row_limit(input logic [GRID_W-1:0] v);
    logic [ROW_CNT_W-1:0] r;
    if (v == '0) r = ROW_CNT_W'(1);
    else if (32'(v) > MAX_ROWS) r = ROW_CNT_W'(MAX_ROWS);
    else r = ROW_CNT_W'(v);
    return r;
  endfunction

  function automatic logic [COL_CNT_W-1:0] col_limit(input logic [GRID_W-1:0] v);
    logic [COL_CNT_W-1:0] r;
    if (v == '0) r = COL_CNT_W'(1);
    else if (32'(v) > MAX_COLS) r = COL_CNT_W'(MAX_COLS);
    else r = COL_CNT_W'(v);
    return r;
  endfunction

  function automatic dist_t sat_inc(input dist_t d);
    dist_t r;
    if (d == DIST_MAX) r = DIST_MAX;
    else r = d + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cbdm_ram.sv
// ----------------------------------------------------------------------------
// cbdm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/cbdm_ctrl.sv
// ----------------------------------------------------------------------------
// cbdm_ctrl
// Pass sequencer: walks the grid in raster order for the forward pass,
// in reverse order for the backward pass, and over the whole store for the
// readout and clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module cbdm_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            go,
  input  wire logic [cbdm_pkg::ROW_CNT_W-1:0]  nr,
  input  wire logic [cbdm_pkg::COL_CNT_W-1:0]  nc,
  output logic                                 busy,
  output logic      [cbdm_pkg::ROW_W-1:0]      rd_row,
  output logic      [cbdm_pkg::COL_W-1:0]      rd_col,
  output cbdm_pkg::stage_t                     s2
);

  cbdm_pkg::state_t state_r, state_nxt;
  logic [cbdm_pkg::ROW_W-1:0] i_r, i_nxt;
  logic [cbdm_pkg::COL_W-1:0] j_r, j_nxt;
  cbdm_pkg::stage_t s2_r, s2_nxt;
  logic [cbdm_pkg::ROW_W-1:0] nr_last;
  logic [cbdm_pkg::COL_W-1:0] nc_last;

  assign nr_last = cbdm_pkg::ROW_W'(nr - cbdm_pkg::ROW_CNT_W'(1));
  assign nc_last = cbdm_pkg::COL_W'(nc - cbdm_pkg::COL_CNT_W'(1));

  always_comb begin
    state_nxt       = state_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    s2_nxt          = '0;
    s2_nxt.row      = i_r;
    s2_nxt.col      = j_r;
    s2_nxt.col_act  = cbdm_pkg::COL_CNT_W'(j_r) < nc;
    s2_nxt.row_act  = cbdm_pkg::ROW_CNT_W'(i_r) < nr;
    s2_nxt.last_row = i_r == nr_last;
    case (state_r)
      cbdm_pkg::ST_CLEAR, cbdm_pkg::ST_SWEEP: begin
        s2_nxt.valid = 1'b1;
        s2_nxt.sweep = 1'b1;
        s2_nxt.emit  = state_r == cbdm_pkg::ST_SWEEP;
        if (j_r == cbdm_pkg::COL_LAST) begin
          j_nxt = '0;
          if (i_r == cbdm_pkg::ROW_LAST) begin
            i_nxt     = '0;
            state_nxt = cbdm_pkg::ST_DRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      cbdm_pkg::ST_IDLE: begin
        if (go) begin
          state_nxt = cbdm_pkg::ST_FWD;
          i_nxt     = '0;
          j_nxt     = '0;
        end
      end
      cbdm_pkg::ST_FWD: begin
        s2_nxt.valid = 1'b1;
        s2_nxt.use_a = i_r != '0;
        s2_nxt.use_b = j_r != '0;
        if (j_r == nc_last) begin
          j_nxt = '0;
          if (i_r == nr_last) begin
            state_nxt = cbdm_pkg::ST_BWD;
            i_nxt     = nr_last;
            j_nxt     = nc_last;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      cbdm_pkg::ST_BWD: begin
        s2_nxt.valid = 1'b1;
        s2_nxt.use_a = i_r != nr_last;
        s2_nxt.use_b = j_r != nc_last;
        if (j_r == '0) begin
          j_nxt = nc_last;
          if (i_r == '0) begin
            state_nxt = cbdm_pkg::ST_SWEEP;
            i_nxt     = '0;
            j_nxt     = '0;
          end else begin
            i_nxt = i_r - 1'b1;
          end
        end else begin
          j_nxt = j_r - 1'b1;
        end
      end
      cbdm_pkg::ST_DRAIN: begin
        // Lets the final sweep write land before marks may use the port.
        state_nxt = cbdm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cbdm_pkg::ST_CLEAR;
        i_nxt     = '0;
        j_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cbdm_pkg::ST_CLEAR;
      i_r        <= '0;
      j_r        <= '0;
      s2_r.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      s2_r    <= s2_nxt;
    end
  end

  assign busy   = state_r != cbdm_pkg::ST_IDLE;
  assign rd_row = i_r;
  assign rd_col = j_r;
  assign s2     = s2_r;

endmodule

`default_nettype wire

### hw/rtl/cbdm_dp.sv
// ----------------------------------------------------------------------------
// cbdm_dp
// Pixel update: relaxes a distance against its two pass neighbors, and in
// the sweep builds the band mask of each row and writes back unreached.
// ----------------------------------------------------------------------------
`default_nettype none

module cbdm_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cbdm_pkg::stage_t              s2,
  input  wire cbdm_pkg::dist_t               st_q,
  input  wire cbdm_pkg::dist_t               lb_q,
  input  wire logic [cbdm_pkg::GAP_W-1:0]    gap,
  output logic                               st_we,
  output logic      [cbdm_pkg::ADDR_W-1:0]   st_waddr,
  output cbdm_pkg::dist_t                    st_wdata,
  output logic                               lb_we,
  output logic      [cbdm_pkg::COL_W-1:0]    lb_waddr,
  output cbdm_pkg::dist_t                    lb_wdata,
  output logic                               out_valid,
  output logic      [cbdm_pkg::ROW_W-1:0]    out_row_index,
  output logic      [cbdm_pkg::MAX_COLS-1:0] out_band_mask,
  output logic                               out_last_row
);

  cbdm_pkg::dist_t prev_r;
  cbdm_pkg::dist_t cand_a, cand_b, relax_val;
  logic in_band, row_end, emit_row;
  logic [cbdm_pkg::MAX_COLS-1:0] mask_acc_r, mask_now;
  logic out_valid_r, out_last_r;
  logic [cbdm_pkg::ROW_W-1:0] out_row_r;
  logic [cbdm_pkg::MAX_COLS-1:0] out_mask_r;

  // The vertical neighbor comes from the line buffer, the horizontal one is
  // the value written for the previous pixel of the same pass.
  always_comb begin
    cand_a    = cbdm_pkg::sat_inc(lb_q);
    cand_b    = cbdm_pkg::sat_inc(prev_r);
    relax_val = st_q;
    if (s2.use_a && (cand_a < relax_val)) relax_val = cand_a;
    if (s2.use_b && (cand_b < relax_val)) relax_val = cand_b;
  end

  assign in_band = s2.col_act && (st_q != cbdm_pkg::DIST_MAX) &&
                   (cbdm_pkg::CMP_W'(st_q) <= cbdm_pkg::CMP_W'(gap));
  assign row_end  = s2.col == cbdm_pkg::COL_LAST;
  assign emit_row = s2.valid && s2.sweep && s2.emit && row_end && s2.row_act;

  always_comb begin
    mask_now         = mask_acc_r;
    mask_now[s2.col] = in_band;
  end

  assign st_we    = s2.valid;
  assign st_waddr = {s2.row, s2.col};
  assign st_wdata = s2.sweep ? cbdm_pkg::DIST_MAX : relax_val;
  assign lb_we    = s2.valid && !s2.sweep;
  assign lb_waddr = s2.col;
  assign lb_wdata = relax_val;

  always_ff @(posedge clk) begin
    if (s2.valid && !s2.sweep) begin
      prev_r <= relax_val;
    end
    if (s2.valid && s2.sweep) begin
      mask_acc_r <= row_end ? '0 : mask_now;
    end
    if (emit_row) begin
      out_row_r  <= s2.row;
      out_mask_r <= mask_now;
      out_last_r <= s2.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit_row;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_band_mask = out_mask_r;
  assign out_last_row  = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/cityblock_distance_band_mask.sv
// ----------------------------------------------------------------------------
// cityblock_distance_band_mask
// Two-pass city-block distance transform over a marked grid, reported as
// one band mask per active row.
// ----------------------------------------------------------------------------
// Use: an item is taken when start is high and busy is low. A mark item
// (in_command low) writes distance zero for pixel (in_row, in_col) if it lies
// inside the active grid; it does not raise busy, so marks may follow each
// cycle. A finish item raises busy and runs a forward raster pass and a
// backward raster pass over the active grid, one pixel per cycle each, a rate
// set by the single write port of the distance memory. Then a sweep reads and
// clears all 4096 entries, one per cycle; the mask of row r appears on out_*
// with out_valid once the sweep has read the last column of row r, and busy
// falls after the sweep and the drain state. Each result is shown for one
// cycle and the receiver cannot stall it. Configuration goes through cfg_we,
// cfg_index and cfg_data; the user must write it only while busy is low, and
// the block itself does not enforce this. After reset the block clears the
// memory with busy high before it takes its first item.
// ----------------------------------------------------------------------------
`default_nettype none

module cityblock_distance_band_mask (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_command,
  input  wire logic [cbdm_pkg::ROW_W-1:0]        in_row,
  input  wire logic [cbdm_pkg::COL_W-1:0]        in_col,
  output logic                                   out_valid,
  output logic      [cbdm_pkg::ROW_W-1:0]        out_row_index,
  output logic      [cbdm_pkg::MAX_COLS-1:0]     out_band_mask,
  output logic                                   out_last_row,
  input  wire logic                              cfg_we,
  input  wire logic [cbdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cbdm_pkg::CFG_W-1:0]        cfg_data
);

  logic [cbdm_pkg::GRID_W-1:0] rows_r, cols_r;
  logic [cbdm_pkg::GAP_W-1:0]  gap_r;
  logic [cbdm_pkg::ROW_CNT_W-1:0] nr;
  logic [cbdm_pkg::COL_CNT_W-1:0] nc;

  logic accept, go, mark_we;
  logic [cbdm_pkg::ROW_W-1:0] rd_row;
  logic [cbdm_pkg::COL_W-1:0] rd_col;
  cbdm_pkg::stage_t s2;

  logic                          dp_st_we, dp_lb_we;
  logic [cbdm_pkg::ADDR_W-1:0]   dp_st_waddr, st_waddr, st_raddr;
  cbdm_pkg::dist_t               dp_st_wdata, st_wdata, dp_lb_wdata;
  logic [cbdm_pkg::COL_W-1:0]    dp_lb_waddr;
  logic                          st_we;
  cbdm_pkg::dist_t               st_ram_q, lb_ram_q, st_q, lb_q;
  logic                          st_hit_r, lb_hit_r;
  cbdm_pkg::dist_t               st_byp_r, lb_byp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= cbdm_pkg::ROWS_RESET;
      cols_r <= cbdm_pkg::COLS_RESET;
      gap_r  <= cbdm_pkg::GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cbdm_pkg::REG_ROWS: rows_r <= cfg_data[cbdm_pkg::GRID_W-1:0];
        cbdm_pkg::REG_COLS: cols_r <= cfg_data[cbdm_pkg::GRID_W-1:0];
        cbdm_pkg::REG_GAP:  gap_r  <= cfg_data[cbdm_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign nr = cbdm_pkg::row_limit(rows_r);
  assign nc = cbdm_pkg::col_limit(cols_r);

  assign accept  = start && !busy;
  assign go      = accept && (in_command == cbdm_pkg::CMD_FINISH);
  assign mark_we = accept && (in_command == cbdm_pkg::CMD_MARK) &&
                   (cbdm_pkg::ROW_CNT_W'(in_row) < nr) &&
                   (cbdm_pkg::COL_CNT_W'(in_col) < nc);

  cbdm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .nr     (nr),
    .nc     (nc),
    .busy   (busy),
    .rd_row (rd_row),
    .rd_col (rd_col),
    .s2     (s2)
  );

  // Marks only arrive while idle, and the sequencer writes only while busy.
  assign st_we    = mark_we || dp_st_we;
  assign st_waddr = dp_st_we ? dp_st_waddr : {in_row, in_col};
  assign st_wdata = dp_st_we ? dp_st_wdata : '0;
  assign st_raddr = {rd_row, rd_col};

  cbdm_ram #(
    .WIDTH (cbdm_pkg::DIST_BITS),
    .DEPTH (cbdm_pkg::MAX_ROWS * cbdm_pkg::MAX_COLS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_ram_q)
  );

  cbdm_ram #(
    .WIDTH (cbdm_pkg::DIST_BITS),
    .DEPTH (cbdm_pkg::MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (dp_lb_we),
    .waddr (dp_lb_waddr),
    .wdata (dp_lb_wdata),
    .raddr (rd_col),
    .rdata (lb_ram_q)
  );

  // A read issued in the same cycle as a write to that entry takes the new
  // value; this covers pass turnarounds and single-column grids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_hit_r <= 1'b0;
      lb_hit_r <= 1'b0;
    end else begin
      st_hit_r <= st_we && (st_waddr == st_raddr);
      lb_hit_r <= dp_lb_we && (dp_lb_waddr == rd_col);
    end
  end

  always_ff @(posedge clk) begin
    st_byp_r <= st_wdata;
    lb_byp_r <= dp_lb_wdata;
  end

  assign st_q = st_hit_r ? st_byp_r : st_ram_q;
  assign lb_q = lb_hit_r ? lb_byp_r : lb_ram_q;

  cbdm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .s2            (s2),
    .st_q          (st_q),
    .lb_q          (lb_q),
    .gap           (gap_r),
    .st_we         (dp_st_we),
    .st_waddr      (dp_st_waddr),
    .st_wdata      (dp_st_wdata),
    .lb_we         (dp_lb_we),
    .lb_waddr      (dp_lb_waddr),
    .lb_wdata      (dp_lb_wdata),
    .out_valid     (out_valid),
    .out_row_index (out_row_index),
    .out_band_mask (out_band_mask),
    .out_last_row  (out_last_row)
  );

  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(mark_we && dp_st_we))
    else $error("mark write collided with a pass write on the distance store");

  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy)
    else $error("finish item taken but the block did not go busy");

  a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("row mask emitted outside a finish run");

  a_line_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    dp_lb_we |-> (busy && !s2.sweep))
    else $error("line buffer written outside a relaxation pass");

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the city-block band mask: edge pixels are marked,
// finish items run the distance transform, and every row mask that comes
// back is checked against a given mask or one from a private distance map.
// ----------------------------------------------------------------------------

module tb_top;

  import cbdm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_GOAL   = 360;
  localparam int unsigned PHASE_CAP   = 40;
  localparam int unsigned TAIL_CYCLES = 4200;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]    row_idx;
    logic [MAX_COLS-1:0] mask;
    logic                last;
  } band_row_t;

  typedef struct packed {
    bit                  is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]    data;
    logic                cmd;
    logic [ROW_W-1:0]    r;
    logic [COL_W-1:0]    c;
    bit                  typed;
    logic [MAX_COLS-1:0] mask;
  } plan_step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_command = CMD_MARK;
  logic [ROW_W-1:0]     in_row = '0;
  logic [COL_W-1:0]     in_col = '0;
  logic                 out_valid;
  logic [ROW_W-1:0]     out_row_index;
  logic [MAX_COLS-1:0]  out_band_mask;
  logic                 out_last_row;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  cityblock_distance_band_mask u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_row        (in_row),
    .in_col        (in_col),
    .out_valid     (out_valid),
    .out_row_index (out_row_index),
    .out_band_mask (out_band_mask),
    .out_last_row  (out_last_row),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Private copy of the block state.
  logic [DIST_BITS-1:0] dist_map [0:MAX_ROWS*MAX_COLS-1];
  logic [GRID_W-1:0]    grid_rows = ROWS_RESET;
  logic [GRID_W-1:0]    grid_cols = COLS_RESET;
  logic [GAP_W-1:0]     gap_now   = GAP_RESET;
  logic [MAX_COLS-1:0]  band_pred [0:MAX_ROWS-1];

  band_row_t   pending_rows [$];
  plan_step_t  plan [$];

  int unsigned cycle_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned finishes     = 0;
  int unsigned rows_checked = 0;
  int unsigned reg_writes   = 0;
  int unsigned errors       = 0;
  bit          steady;

  initial begin
    for (int k = 0; k < MAX_ROWS * MAX_COLS; k++) dist_map[k] = DIST_MAX;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int unsigned grid_span(input logic [GRID_W-1:0] v, input int unsigned top);
    if (v == '0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic void relax_from(input int unsigned at, input int unsigned from);
    logic [DIST_BITS-1:0] cand;
    cand = (dist_map[from] == DIST_MAX) ? DIST_MAX : dist_map[from] + 1'b1;
    if (cand < dist_map[at]) dist_map[at] = cand;
  endfunction

  function automatic void mark_pixel(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    if (r < grid_span(grid_rows, MAX_ROWS) && c < grid_span(grid_cols, MAX_COLS))
      dist_map[r * MAX_COLS + c] = '0;
  endfunction

  // Forward and backward raster passes, then one mask per active row; the
  // map is left cleared as the block leaves its store.
  function automatic int unsigned run_transform();
    int unsigned nr;
    int unsigned nc;
    int unsigned at;
    logic [MAX_COLS-1:0] m;
    nr = grid_span(grid_rows, MAX_ROWS);
    nc = grid_span(grid_cols, MAX_COLS);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        at = i * MAX_COLS + j;
        if (i > 0) relax_from(at, at - MAX_COLS);
        if (j > 0) relax_from(at, at - 1);
      end
    end
    for (int i = nr - 1; i >= 0; i--) begin
      for (int j = nc - 1; j >= 0; j--) begin
        at = i * MAX_COLS + j;
        if (i + 1 < nr) relax_from(at, at + MAX_COLS);
        if (j + 1 < nc) relax_from(at, at + 1);
      end
    end
    for (int i = 0; i < nr; i++) begin
      m = '0;
      for (int j = 0; j < nc; j++) begin
        at = i * MAX_COLS + j;
        if (dist_map[at] != DIST_MAX && dist_map[at] <= gap_now) m[j] = 1'b1;
      end
      band_pred[i] = m;
    end
    for (int k = 0; k < MAX_ROWS * MAX_COLS; k++) dist_map[k] = DIST_MAX;
    return nr;
  endfunction

  function automatic plan_step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
    plan_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic plan_step_t mark_step(input logic [ROW_W-1:0] r,
                                           input logic [COL_W-1:0] c);
    plan_step_t s;
    s = '0;
    s.cmd = CMD_MARK;
    s.r = r;
    s.c = c;
    return s;
  endfunction

  // A typed finish expects the given mask on every emitted row.
  function automatic plan_step_t finish_step(input bit typed, input logic [MAX_COLS-1:0] mask);
    plan_step_t s;
    s = '0;
    s.cmd = CMD_FINISH;
    s.typed = typed;
    s.mask = mask;
    return s;
  endfunction

  task automatic send_item(input logic cmd, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c, input bit typed,
                           input logic [MAX_COLS-1:0] typed_mask);
    int unsigned n;
    band_row_t   b;
    if (!steady) begin
      while ($urandom_range(0, 99) < 16) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_row     <= r;
    in_col     <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    items_sent++;
    steady = (items_sent >= 150 && items_sent < 230);
    if (cmd == CMD_MARK) begin
      mark_pixel(r, c);
    end else begin
      finishes++;
      n = run_transform();
      for (int i = 0; i < n; i++) begin
        b.row_idx = ROW_W'(i);
        b.mask    = typed ? typed_mask : band_pred[i];
        b.last    = (i == n - 1);
        pending_rows.push_back(b);
      end
    end
  endtask

  // Registers change only once the block has drained and dropped busy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_ROWS: grid_rows = data[GRID_W-1:0];
      REG_COLS: grid_cols = data[GRID_W-1:0];
      REG_GAP:  gap_now   = data[GAP_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : check_rows
    band_row_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_rows.size() == 0) begin
        $error("row mask for row %0d arrived with none pending", out_row_index);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (out_row_index !== want.row_idx) begin
          $error("row_index: expected %0d, got %0d", want.row_idx, out_row_index);
          errors++;
        end
        if (out_band_mask !== want.mask) begin
          $error("band_mask: expected %h, got %h", want.mask, out_band_mask);
          errors++;
        end
        if (out_last_row !== want.last) begin
          $error("last_row: expected %0b, got %0b", want.last, out_last_row);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned big_left;
    int unsigned marks;
    int unsigned nr;
    int unsigned nc;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;

    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Finish straight after reset: 64 empty rows.
    plan.push_back(finish_step(1, '0));
    // One row, whole width, widest band: every column reached.
    plan.push_back(cfg_step(REG_ROWS, 8'd1));
    plan.push_back(cfg_step(REG_COLS, 8'd64));
    plan.push_back(cfg_step(REG_GAP, 8'd254));
    plan.push_back(mark_step(6'd0, 6'd0));
    plan.push_back(finish_step(1, '1));
    // Zero band keeps only the edge pixel itself.
    plan.push_back(cfg_step(REG_GAP, 8'd0));
    plan.push_back(mark_step(6'd0, 6'd63));
    plan.push_back(finish_step(1, 64'h8000_0000_0000_0000));
    // Zero grid registers act as one; unreached stays out at the top gap.
    plan.push_back(cfg_step(REG_ROWS, 8'd0));
    plan.push_back(cfg_step(REG_COLS, 8'd0));
    plan.push_back(cfg_step(REG_GAP, 8'd255));
    plan.push_back(mark_step(6'd0, 6'd1));
    plan.push_back(finish_step(1, '0));
    plan.push_back(mark_step(6'd0, 6'd0));
    plan.push_back(finish_step(1, 64'h1));
    // Oversized grid registers clamp to the full grid, two corners marked.
    plan.push_back(cfg_step(REG_ROWS, 8'hC8));
    plan.push_back(cfg_step(REG_COLS, 8'h7F));
    plan.push_back(cfg_step(REG_GAP, 8'd1));
    plan.push_back(mark_step(6'd63, 6'd63));
    plan.push_back(mark_step(6'd0, 6'd0));
    plan.push_back(mark_step(6'd31, 6'd32));
    plan.push_back(finish_step(0, '0));
    // A write to the unused register index must leave the grid alone.
    plan.push_back(cfg_step(REG_ROWS, 8'd2));
    plan.push_back(cfg_step(REG_COLS, 8'd3));
    plan.push_back(cfg_step(REG_GAP, 8'd2));
    plan.push_back(mark_step(6'd1, 6'd2));
    plan.push_back(cfg_step(REG_NONE, 8'd0));
    plan.push_back(mark_step(6'd0, 6'd0));
    plan.push_back(finish_step(0, '0));
    // A mark left outside a shrunken grid is dropped and cleared.
    plan.push_back(cfg_step(REG_ROWS, 8'd64));
    plan.push_back(cfg_step(REG_COLS, 8'd64));
    plan.push_back(cfg_step(REG_GAP, 8'd3));
    plan.push_back(mark_step(6'd40, 6'd50));
    plan.push_back(mark_step(6'd1, 6'd1));
    plan.push_back(cfg_step(REG_ROWS, 8'd8));
    plan.push_back(cfg_step(REG_COLS, 8'd8));
    plan.push_back(finish_step(0, '0));
    plan.push_back(cfg_step(REG_ROWS, 8'd64));
    plan.push_back(cfg_step(REG_COLS, 8'd64));
    plan.push_back(finish_step(1, '0));

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_reg(plan[k].idx, plan[k].data);
      else send_item(plan[k].cmd, plan[k].r, plan[k].c, plan[k].typed, plan[k].mask);
    end

    // Random phases: mostly small grids, a few near full size.
    phase = 0;
    big_left = 3;
    while (items_sent < ITEM_GOAL && phase < PHASE_CAP) begin
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        if (big_left > 0 && $urandom_range(0, 11) == 0) begin
          big_left--;
          write_reg(REG_ROWS, {1'($urandom_range(0, 1)), 7'($urandom_range(48, 127))});
          write_reg(REG_COLS, {1'($urandom_range(0, 1)), 7'($urandom_range(48, 127))});
        end else begin
          write_reg(REG_ROWS, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 8))});
          write_reg(REG_COLS, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 16))});
        end
        if ($urandom_range(0, 9) < 7) write_reg(REG_GAP, 8'($urandom_range(0, 4)));
        else write_reg(REG_GAP, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) write_reg(REG_NONE, 8'($urandom_range(0, 255)));
      end
      marks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(4, 30);
      for (int k = 0; k < marks; k++) begin
        nr = grid_span(grid_rows, MAX_ROWS);
        nc = grid_span(grid_cols, MAX_COLS);
        if ($urandom_range(0, 99) < 80) begin
          r = ROW_W'($urandom_range(0, nr - 1));
          c = COL_W'($urandom_range(0, nc - 1));
        end else begin
          r = ROW_W'($urandom_range(0, MAX_ROWS - 1));
          c = COL_W'($urandom_range(0, MAX_COLS - 1));
        end
        send_item(CMD_MARK, r, c, 0, '0);
        // Now and then shrink the grid under marks already placed.
        if (k == marks / 2 && $urandom_range(0, 7) == 0) begin
          write_reg(REG_ROWS, 8'($urandom_range(1, nr)));
          write_reg(REG_COLS, 8'($urandom_range(1, nc)));
        end
      end
      send_item(CMD_FINISH, '0, '0, 0, '0);
      phase++;
    end

    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    // Let the store clearing run out and catch any stray mask.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d items accepted, %0d of them finishes, %0d register writes",
             items_sent, finishes, reg_writes);
    $display("tb_top: %0d row masks compared over %0d random phases", rows_checked, phase);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
